### sv/spd_pkg.sv
// Shared types and fixed widths for the segment pair squared distance pipeline.
package spd_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int DIST_W     = 50;
	localparam int PARAM_W    = FRAC_BITS + 1;
	localparam int DW         = COORD_BITS + 1;
	localparam int DOTW       = 2 * DW + 2;
	localparam int HALF       = DOTW / 2;
	localparam int PW         = 2 * DOTW;
	localparam int PCW        = DW + PARAM_W + 2;
	localparam int MW         = PCW - 1;
	localparam int MH         = MW / 2;
	localparam int ML         = MW - MH;
	localparam int ACCW       = 2 * MW + 2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_x;
		logic signed [COORD_BITS-1:0] a_y;
		logic signed [COORD_BITS-1:0] a_z;
		logic signed [COORD_BITS-1:0] b_x;
		logic signed [COORD_BITS-1:0] b_y;
		logic signed [COORD_BITS-1:0] b_z;
		logic signed [COORD_BITS-1:0] c_x;
		logic signed [COORD_BITS-1:0] c_y;
		logic signed [COORD_BITS-1:0] c_z;
		logic signed [COORD_BITS-1:0] d_x;
		logic signed [COORD_BITS-1:0] d_y;
		logic signed [COORD_BITS-1:0] d_z;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0]  dist_sq;
		logic [PARAM_W-1:0] param_first;
		logic [PARAM_W-1:0] param_second;
	} result_t;

	typedef struct packed {
		logic [2:0][DW-1:0] u;
		logic [2:0][DW-1:0] v;
		logic [2:0][DW-1:0] w;
	} geo_t;

endpackage

### sv/segment_pair_distance_sq_top.sv
// Top level: squared closest distance and closest-point parameters of two 3D segments.
//
// Command channel: a beat (twelve signed coordinates in item) is taken at every
// clock edge where start is high; busy is always low, so one pair may enter each
// cycle. Result channel: each result beat (dist_sq, param_first, param_second)
// appears on result for exactly one cycle with strobe high; there is no
// backpressure, and the receiver must take it in that cycle.
// Pipeline: seven stages form the differences, dot products, split wide
// products and clamped numerators and divisors; two 17-stage restoring
// dividers (an entry stage, then one quotient bit per stage) produce the
// parameters; four more stages rebuild the closest offset, square it in split
// partial products and sum it.
// Throughput: one pair per cycle, sustained.
// Reset: arst_n clears all valid bits; pairs in flight are dropped and no strobe
// follows. Data registers are not reset.
module segment_pair_distance_sq_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  spd_pkg::item_t   item,
	output logic             strobe,
	output spd_pkg::result_t result
);
	import spd_pkg::*;

	localparam int DQ = FRAC_BITS + 1;

	function automatic logic signed [DOTW-1:0] dot3(input logic [2:0][DW-1:0] x,
	                                                 input logic [2:0][DW-1:0] y);
		logic signed [DOTW-1:0] acc;
		acc = '0;
		for (int i = 0; i < 3; i++)
			acc = acc + DOTW'($signed(x[i]) * $signed(y[i]));
		return acc;
	endfunction

	assign busy = 1'b0;

	// s1: differences
	geo_t geo_c, geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6, geo_s7;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_comb begin
		geo_c.u[0] = DW'(item.b_x) - DW'(item.a_x);
		geo_c.u[1] = DW'(item.b_y) - DW'(item.a_y);
		geo_c.u[2] = DW'(item.b_z) - DW'(item.a_z);
		geo_c.v[0] = DW'(item.d_x) - DW'(item.c_x);
		geo_c.v[1] = DW'(item.d_y) - DW'(item.c_y);
		geo_c.v[2] = DW'(item.d_z) - DW'(item.c_z);
		geo_c.w[0] = DW'(item.a_x) - DW'(item.c_x);
		geo_c.w[1] = DW'(item.a_y) - DW'(item.c_y);
		geo_c.w[2] = DW'(item.a_z) - DW'(item.c_z);
	end

	// s2: dot products
	logic signed [DOTW-1:0] da_s2, db_s2, dc_s2, dd_s2, de_s2;
	// s3: split partial products
	logic signed [DOTW-1:0] da_s3, db_s3, dc_s3, dd_s3, de_s3;
	logic signed [DOTW-1:0] ma_c [6];
	logic signed [DOTW-1:0] mb_c [6];
	logic signed [DOTW+HALF:0] plo_s3 [6];
	logic signed [DOTW+HALF-1:0] phi_s3 [6];
	// s4: full products
	logic signed [DOTW-1:0] da_s4, db_s4, dc_s4, dd_s4, de_s4;
	logic signed [PW-1:0] prod_s4 [6];
	// s5: raw numerators and denominator
	logic signed [DOTW-1:0] da_s5, db_s5, dc_s5, dd_s5, de_s5;
	logic signed [PW-1:0] den_s5, sn_s5, tn_s5;
	// s6: first clamp
	logic signed [DOTW-1:0] da_s6, db_s6, dd_s6;
	logic signed [PW-1:0] sn_c6, sd_c6, tn_c6, td_c6;
	logic signed [PW-1:0] sn_s6, sd_s6, tn_s6, td_s6;
	// s7: re-projection
	logic signed [DOTW:0] nd_c7;
	logic signed [PW-1:0] sn_c7, sd_c7, tn_c7;
	logic signed [PW-1:0] sn_s7, sd_s7, tn_s7, td_s7;

	always_comb begin
		ma_c[0] = da_s2; mb_c[0] = dc_s2;
		ma_c[1] = db_s2; mb_c[1] = db_s2;
		ma_c[2] = db_s2; mb_c[2] = de_s2;
		ma_c[3] = dc_s2; mb_c[3] = dd_s2;
		ma_c[4] = da_s2; mb_c[4] = de_s2;
		ma_c[5] = db_s2; mb_c[5] = dd_s2;
	end

	always_comb begin
		sd_c6 = den_s5;
		td_c6 = den_s5;
		sn_c6 = sn_s5;
		tn_c6 = tn_s5;
		if (den_s5 <= 0) begin
			sn_c6 = '0;
			sd_c6 = PW'(1);
			tn_c6 = PW'(de_s5);
			td_c6 = PW'(dc_s5);
		end else if (sn_s5 < 0) begin
			sn_c6 = '0;
			tn_c6 = PW'(de_s5);
			td_c6 = PW'(dc_s5);
		end else if (sn_s5 > den_s5) begin
			sn_c6 = den_s5;
			tn_c6 = PW'(de_s5) + PW'(db_s5);
			td_c6 = PW'(dc_s5);
		end
	end

	always_comb begin
		sn_c7 = sn_s6;
		sd_c7 = sd_s6;
		tn_c7 = tn_s6;
		nd_c7 = (tn_s6 < 0) ? -(DOTW+1)'(dd_s6) : (DOTW+1)'(db_s6) - (DOTW+1)'(dd_s6);
		if (tn_s6 < 0 || tn_s6 > td_s6) begin
			tn_c7 = (tn_s6 < 0) ? '0 : td_s6;
			if (nd_c7 < 0) begin
				sn_c7 = '0;
			end else if (nd_c7 > (DOTW+1)'(da_s6)) begin
				sn_c7 = sd_s6;
			end else begin
				sn_c7 = PW'(nd_c7);
				sd_c7 = PW'(da_s6);
			end
		end
	end

	always_ff @(posedge clk) begin
		geo_s1 <= geo_c;
		geo_s2 <= geo_s1;
		da_s2 <= dot3(geo_s1.u, geo_s1.u);
		db_s2 <= dot3(geo_s1.u, geo_s1.v);
		dc_s2 <= dot3(geo_s1.v, geo_s1.v);
		dd_s2 <= dot3(geo_s1.u, geo_s1.w);
		de_s2 <= dot3(geo_s1.v, geo_s1.w);
		geo_s3 <= geo_s2;
		da_s3 <= da_s2; db_s3 <= db_s2; dc_s3 <= dc_s2; dd_s3 <= dd_s2; de_s3 <= de_s2;
		for (int i = 0; i < 6; i++) begin
			plo_s3[i] <= ma_c[i] * $signed({1'b0, mb_c[i][HALF-1:0]});
			phi_s3[i] <= ma_c[i] * $signed(mb_c[i][DOTW-1:HALF]);
		end
		geo_s4 <= geo_s3;
		da_s4 <= da_s3; db_s4 <= db_s3; dc_s4 <= dc_s3; dd_s4 <= dd_s3; de_s4 <= de_s3;
		for (int i = 0; i < 6; i++)
			prod_s4[i] <= (PW'(phi_s3[i]) <<< HALF) + PW'(plo_s3[i]);
		geo_s5 <= geo_s4;
		da_s5 <= da_s4; db_s5 <= db_s4; dc_s5 <= dc_s4; dd_s5 <= dd_s4; de_s5 <= de_s4;
		den_s5 <= prod_s4[0] - prod_s4[1];
		sn_s5  <= prod_s4[2] - prod_s4[3];
		tn_s5  <= prod_s4[4] - prod_s4[5];
		geo_s6 <= geo_s5;
		da_s6 <= da_s5; db_s6 <= db_s5; dd_s6 <= dd_s5;
		sn_s6 <= sn_c6; sd_s6 <= sd_c6; tn_s6 <= tn_c6; td_s6 <= td_c6;
		geo_s7 <= geo_s6;
		sn_s7 <= sn_c7; sd_s7 <= sd_c7; tn_s7 <= tn_c7; td_s7 <= td_s6;
	end

	// parameter dividers
	logic [PARAM_W-1:0] sc_d, tc_d;

	spd_div u_div_s (.clk(clk), .num(sn_s7), .den(sd_s7), .quo(sc_d));
	spd_div u_div_t (.clk(clk), .num(tn_s7), .den(td_s7), .quo(tc_d));

	geo_t geo_dq [DQ];
	logic vld_dq [DQ];

	always_ff @(posedge clk) begin
		geo_dq[0] <= geo_s7;
		for (int k = 1; k < DQ; k++)
			geo_dq[k] <= geo_dq[k-1];
	end

	// closest offset and its square
	logic [PARAM_W-1:0] sc_s25, tc_s25, sc_s26, tc_s26, sc_s27, tc_s27;
	logic [2:0][DW-1:0] w_s25;
	logic signed [DW+PARAM_W:0] su_s25 [3];
	logic signed [DW+PARAM_W:0] tv_s25 [3];
	logic signed [PCW-1:0] pc_c [3];
	logic [MW-1:0] mag_s26 [3];
	logic [2*MH-1:0] hh_s27 [3];
	logic [MH+ML-1:0] hl_s27 [3];
	logic [2*ML-1:0] ll_s27 [3];
	logic vld_s25, vld_s26, vld_s27;
	logic [ACCW-1:0] acc_c;
	logic [DIST_W-1:0] dist_c;
	result_t result_q;
	logic strobe_q;

	always_comb begin
		for (int i = 0; i < 3; i++)
			pc_c[i] = (PCW'($signed(w_s25[i])) <<< FRAC_BITS) + PCW'(su_s25[i])
			        - PCW'(tv_s25[i]);
		acc_c = '0;
		for (int i = 0; i < 3; i++)
			acc_c = acc_c + (ACCW'(hh_s27[i]) << (2 * ML)) + (ACCW'(hl_s27[i]) << (ML + 1))
			      + ACCW'(ll_s27[i]);
		if (acc_c[ACCW-1:FRAC_BITS+DIST_W] != '0)
			dist_c = '1;
		else
			dist_c = acc_c[FRAC_BITS+DIST_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		sc_s25 <= sc_d;
		tc_s25 <= tc_d;
		w_s25  <= geo_dq[DQ-1].w;
		for (int i = 0; i < 3; i++) begin
			su_s25[i] <= $signed({1'b0, sc_d}) * $signed(geo_dq[DQ-1].u[i]);
			tv_s25[i] <= $signed({1'b0, tc_d}) * $signed(geo_dq[DQ-1].v[i]);
		end
		sc_s26 <= sc_s25;
		tc_s26 <= tc_s25;
		for (int i = 0; i < 3; i++)
			mag_s26[i] <= pc_c[i][PCW-1] ? MW'(-pc_c[i]) : MW'(pc_c[i]);
		sc_s27 <= sc_s26;
		tc_s27 <= tc_s26;
		for (int i = 0; i < 3; i++) begin
			hh_s27[i] <= mag_s26[i][MW-1:ML] * mag_s26[i][MW-1:ML];
			hl_s27[i] <= mag_s26[i][MW-1:ML] * mag_s26[i][ML-1:0];
			ll_s27[i] <= mag_s26[i][ML-1:0] * mag_s26[i][ML-1:0];
		end
		result_q.dist_sq      <= dist_c;
		result_q.param_first  <= sc_s27;
		result_q.param_second <= tc_s27;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
			for (int k = 0; k < DQ; k++)
				vld_dq[k] <= 1'b0;
			vld_s25  <= 1'b0;
			vld_s26  <= 1'b0;
			vld_s27  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
			vld_dq[0] <= vld_s7;
			for (int k = 1; k < DQ; k++)
				vld_dq[k] <= vld_dq[k-1];
			vld_s25  <= vld_dq[DQ-1];
			vld_s26  <= vld_s25;
			vld_s27  <= vld_s26;
			strobe_q <= vld_s27;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

### sv/spd_div.sv
// Pipelined restoring fraction divider, one quotient bit per stage, clamped to 0..1.0.
module spd_div (
	input  logic                          clk,
	input  logic signed [spd_pkg::PW-1:0] num,
	input  logic signed [spd_pkg::PW-1:0] den,
	output logic [spd_pkg::PARAM_W-1:0]   quo
);
	import spd_pkg::*;

	logic [PW-1:0]      rem_st [FRAC_BITS+1];
	logic [PW-1:0]      den_st [FRAC_BITS+1];
	logic [PARAM_W-1:0] quo_st [FRAC_BITS+1];
	logic               byp_st [FRAC_BITS+1];

	logic zero_c, one_c;

	always_comb begin
		zero_c = (den <= 0) || (num <= 0);
		one_c  = !zero_c && (num >= den);
	end

	always_ff @(posedge clk) begin
		rem_st[0] <= num;
		den_st[0] <= den;
		byp_st[0] <= zero_c || one_c;
		quo_st[0] <= one_c ? PARAM_W'(1) << FRAC_BITS : '0;
	end

	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
		logic [PW-1:0] r2;
		logic          ge;

		always_comb begin
			r2 = rem_st[k-1] << 1;
			ge = !byp_st[k-1] && (r2 >= den_st[k-1]);
		end

		always_ff @(posedge clk) begin
			rem_st[k] <= ge ? r2 - den_st[k-1] : r2;
			den_st[k] <= den_st[k-1];
			byp_st[k] <= byp_st[k-1];
			quo_st[k] <= byp_st[k-1] ? quo_st[k-1] : {quo_st[k-1][PARAM_W-2:0], ge};
		end
	end

	assign quo = quo_st[FRAC_BITS];

endmodule
